>>> hdl/pidc_pkg.sv
// pidc_pkg: shared constants, register indexes and sequencer states of the
// clamped pid controller; no dependencies
`default_nettype none

package pidc_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int DT_W           = 16;  // unsigned q8.8 time step
  localparam int GAIN_W         = 16;  // signed q8.8 gains
  localparam int INTEG_W        = 48;  // integral and derivative width
  localparam int HALF_W         = INTEG_W / 2;
  localparam int FRAC_W         = 16;  // fraction bits of the q.16 sum
  localparam int P_SHIFT        = 8;   // q.8 proportional product to q.16
  localparam int ACC_W          = 65;  // holds p + i + d without overflow
  localparam int CFG_IDX_W      = 3;

  localparam logic OP_CLEAR = 1'b1;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd256;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd0;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_MAX = 3'd0,
    REG_OUT_MIN = 3'd1,
    REG_GAIN_P  = 3'd2,
    REG_GAIN_D  = 3'd3,
    REG_GAIN_I  = 3'd4
  } pidc_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_ED,
    S_MUL_PE,
    S_MUL_IL,
    S_MUL_IH,
    S_ACC_IH,
    S_WAIT_DIV,
    S_MUL_DL,
    S_MUL_DH,
    S_ACC_DH,
    S_DONE
  } pidc_state_t;

endpackage

`default_nettype wire

>>> hdl/pid_controller_clamped.sv
// a control step waits for the bit-serial divider that forms the derivative,
// unless the time step is zero; a clear goes straight to the result. one item
// at a time; the next input is taken the cycle after the result is loaded,
// even if it still waits downstream.
// reset (synchronous, active low) clears integral and last error, loads gain and
// limit defaults and empties the output register.
`default_nettype none

module pid_controller_clamped
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CFG_W = (DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration writes
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  // input channel
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic                         in_operation,
  input  wire logic signed [DATA_WIDTH-1:0] in_target,
  input  wire logic signed [DATA_WIDTH-1:0] in_measured,
  input  wire logic [DT_W-1:0]              in_time_step,
  // result channel
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic signed [DATA_WIDTH-1:0] out_drive,
  output      logic                         out_zero_step,
  output      logic                         out_clamped
);

  localparam int ERR_W  = DATA_WIDTH + 1;           // target - measured
  localparam int DIFF_W = DATA_WIDTH + 2;           // error - last error
  localparam int NUM_W  = ERR_W + FRAC_W;           // |diff| * 65536
  localparam int MA_W   = DT_W + 1;                 // gain or zero-extended dt
  localparam int MB_W   = (ERR_W > HALF_W + 1) ? ERR_W : HALF_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int IS_W   = ((PROD_W > INTEG_W) ? PROD_W : INTEG_W) + 1;
  localparam int LIM_W  = ACC_W - FRAC_W;

  localparam logic signed [IS_W-1:0] I_MAX = IS_W'(INTEG_MAX);
  localparam logic signed [IS_W-1:0] I_MIN = IS_W'(INTEG_MIN);

  // sequencer
  pidc_state_t state_r, state_nxt;

  // configuration registers
  logic signed [DATA_WIDTH-1:0] out_max_r, out_min_r;
  logic signed [GAIN_W-1:0]     gain_p_r, gain_d_r, gain_i_r;

  // controller state
  logic signed [ERR_W-1:0]   last_err_r;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;

  // per-item working registers
  logic                      op_r;
  logic                      zero_r;
  logic signed [ERR_W-1:0]   err_r;
  logic [DT_W-1:0]           dt_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;

  // output register
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_drive_r;
  logic                         out_zero_r;
  logic                         out_clamp_r;
  logic                         out_load;

  // shared multiplier
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  prod_x;

  // derivative divider
  logic                      div_start;
  logic                      div_done;
  logic signed [INTEG_W-1:0] deriv;
  logic signed [DIFF_W-1:0]  diff, diff_mag;
  logic [NUM_W-1:0]          div_num;

  // integral and clamp datapath
  logic signed [IS_W-1:0]       integ_sum;
  logic signed [ACC_W-1:0]      max_x, min_x;
  logic                         over_max, under_min;
  logic signed [DATA_WIDTH-1:0] drive_val;
  logic signed [ERR_W-1:0]      err_in;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_zero_step = out_zero_r;
  assign out_clamped   = out_clamp_r;

  assign err_in = ERR_W'(in_target) - ERR_W'(in_measured);

  pidc_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // derivative numerator: |error - last error| shifted into q.16, sign kept aside
  assign diff     = DIFF_W'(err_r) - DIFF_W'(last_err_r);
  assign diff_mag = diff[DIFF_W-1] ? -diff : diff;
  assign div_num  = {diff_mag[ERR_W-1:0], {FRAC_W{1'b0}}};

  pidc_div #(
    .N_W (NUM_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .dividend   (div_num),
    .divisor    (dt_r),
    .negate     (diff[DIFF_W-1]),
    .done_r     (div_done),
    .quotient_r (deriv)
  );

  // sequencer: at most one multiplier operand pair per state, its product lands in the cycle after
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_operation == OP_CLEAR) ? S_DONE : S_MUL_ED;
        end
      end
      S_MUL_ED: begin
        // error * dt for the integral; divider starts alongside unless the time step is zero
        mul_a     = {1'b0, dt_r};
        mul_b     = MB_W'(err_r);
        div_start = ~zero_r;
        state_nxt = S_MUL_PE;
      end
      S_MUL_PE: begin
        mul_a     = MA_W'(gain_p_r);
        mul_b     = MB_W'(err_r);
        state_nxt = S_MUL_IL;
      end
      S_MUL_IL: begin
        mul_a     = MA_W'(gain_i_r);
        mul_b     = MB_W'({1'b0, integ_r[HALF_W-1:0]});
        state_nxt = S_MUL_IH;
      end
      S_MUL_IH: begin
        mul_a     = MA_W'(gain_i_r);
        mul_b     = MB_W'(signed'(integ_r[INTEG_W-1:HALF_W]));
        state_nxt = S_ACC_IH;
      end
      S_ACC_IH: begin
        state_nxt = S_WAIT_DIV;
      end
      S_WAIT_DIV: begin
        // zero time step skips the derivative term
        if (zero_r) begin
          state_nxt = S_DONE;
        end else if (div_done) begin
          state_nxt = S_MUL_DL;
        end
      end
      S_MUL_DL: begin
        mul_a     = MA_W'(gain_d_r);
        mul_b     = MB_W'({1'b0, deriv[HALF_W-1:0]});
        state_nxt = S_MUL_DH;
      end
      S_MUL_DH: begin
        mul_a     = MA_W'(gain_d_r);
        mul_b     = MB_W'(signed'(deriv[INTEG_W-1:HALF_W]));
        state_nxt = S_ACC_DH;
      end
      S_ACC_DH: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for a free output register
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // accumulator of the q.16 sum; each add takes the product of the state before
  assign prod_x = ACC_W'(prod_r);

  always_comb begin
    unique case (state_r)
      S_MUL_PE:           acc_nxt = '0;
      S_MUL_IL:           acc_nxt = acc_r + (prod_x <<< P_SHIFT);  // p term
      S_MUL_IH, S_MUL_DH: acc_nxt = acc_r + prod_x;                // low halves
      S_ACC_IH, S_ACC_DH: acc_nxt = acc_r + (prod_x <<< HALF_W);   // high halves
      default:            acc_nxt = acc_r;
    endcase
  end

  // saturating integral update with error * dt
  assign integ_sum = IS_W'(integ_r) + IS_W'(prod_r);

  always_comb begin
    if (integ_sum > I_MAX) begin
      integ_nxt = INTEG_MAX;
    end else if (integ_sum < I_MIN) begin
      integ_nxt = INTEG_MIN;
    end else begin
      integ_nxt = integ_sum[INTEG_W-1:0];
    end
  end

  // clamp: max is tested first, so crossed limits favor out_max
  assign max_x     = {LIM_W'(out_max_r), {FRAC_W{1'b0}}};
  assign min_x     = {LIM_W'(out_min_r), {FRAC_W{1'b0}}};
  assign over_max  = (acc_r > max_x);
  assign under_min = (acc_r < min_x);

  always_comb begin
    priority if (over_max) begin
      drive_val = out_max_r;
    end else if (under_min) begin
      drive_val = out_min_r;
    end else begin
      // floor of the q.16 sum
      drive_val = acc_r[DATA_WIDTH+FRAC_W-1:FRAC_W];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_max_r <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
      out_min_r <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
      gain_p_r  <= GAIN_P_RST;
      gain_d_r  <= GAIN_D_RST;
      gain_i_r  <= GAIN_I_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUT_MAX: out_max_r <= cfg_data[DATA_WIDTH-1:0];
        REG_OUT_MIN: out_min_r <= cfg_data[DATA_WIDTH-1:0];
        REG_GAIN_P:  gain_p_r  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:  gain_d_r  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:  gain_i_r  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // controller state: integral and last error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else begin
      if (state_r == S_MUL_PE) begin
        integ_r <= integ_nxt;
      end
      if (out_load) begin
        if (op_r == OP_CLEAR) begin
          integ_r    <= '0;
          last_err_r <= '0;
        end else begin
          last_err_r <= err_r;
        end
      end
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_operation;
      err_r  <= err_in;
      dt_r   <= in_time_step;
      zero_r <= (in_time_step == '0);
    end
    acc_r <= acc_nxt;
    if (out_load) begin
      if (op_r == OP_CLEAR) begin
        out_drive_r <= '0;
        out_zero_r  <= 1'b0;
        out_clamp_r <= 1'b0;
      end else begin
        out_drive_r <= drive_val;
        out_zero_r  <= zero_r;
        out_clamp_r <= over_max | under_min;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/pidc_mul.sv
// pidc_mul: shared signed multiplier with registered product
// no package dependency
`default_nettype none

module pidc_mul #(
  parameter int A_W = 17,
  parameter int B_W = 25
) (
  input  wire logic                      clk,
  input  wire logic signed [A_W-1:0]     a,
  input  wire logic signed [B_W-1:0]     b,
  output      logic signed [A_W+B_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

endmodule

`default_nettype wire

>>> hdl/pidc_div.sv
// pidc_div: bit-serial restoring divider for the derivative term,
// one quotient bit per cycle, signed result saturated to 48 bits; uses pidc_pkg
`default_nettype none

module pidc_div
  import pidc_pkg::*;
#(
  parameter int N_W = 33
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [N_W-1:0]            dividend,
  input  wire logic [DT_W-1:0]           divisor,
  input  wire logic                      negate,
  output      logic                      done_r,
  output      logic signed [INTEG_W-1:0] quotient_r
);

  localparam int CNT_W = $clog2(N_W + 1);
  localparam int QE_W  = (N_W > INTEG_W) ? N_W : INTEG_W;
  localparam logic [QE_W-1:0] POS_LIM = QE_W'(INTEG_MAX);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DT_W-1:0]  rem_r;
  logic [N_W-1:0]   quo_r;
  logic [DT_W-1:0]  divisor_r;
  logic             neg_r;

  logic [DT_W:0]            shifted;
  logic [DT_W+1:0]          trial;
  logic                     q_bit;
  logic [QE_W-1:0]          q_e;
  logic signed [INTEG_W-1:0] quotient_nxt;

  assign shifted = {rem_r, quo_r[N_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor_r};
  assign q_bit   = ~trial[DT_W+1];
  assign q_e     = QE_W'(quo_r);

  // truncated quotient with the dividend sign, clipped to the 48-bit range
  always_comb begin
    if (q_e > POS_LIM) begin
      quotient_nxt = neg_r ? INTEG_MIN : INTEG_MAX;
    end else if (neg_r) begin
      quotient_nxt = ~q_e[INTEG_W-1:0] + 1'b1;
    end else begin
      quotient_nxt = q_e[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(N_W);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= '0;
      quo_r     <= dividend;
      divisor_r <= divisor;
      neg_r     <= negate;
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= q_bit ? trial[DT_W-1:0] : shifted[DT_W-1:0];
      quo_r <= {quo_r[N_W-2:0], q_bit};
    end else if (busy_r) begin
      quotient_r <= quotient_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pidc_checker.sv
// pidc_checker: port-level assertions for pid_controller_clamped and the bind
// that attaches them; uses pidc_pkg
`default_nettype none

module pidc_checker
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [DATA_WIDTH-1:0] out_drive,
  input wire logic                         out_zero_step,
  input wire logic                         out_clamped
);

  // items taken in but not yet handed out
  logic [1:0] pend_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive)
      && $stable(out_zero_step) && $stable(out_clamped))
    else $error("result changed while stalled");

  // one item at a time: busy right after a transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken while an item is at work");

  // no invented results
  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending item");

  // a waiting result plus one item at work is the most the block holds
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> pend_r == 2'd0 || pend_r == 2'd1)
    else $error("input taken with two items pending");

endmodule

bind pid_controller_clamped pidc_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_pidc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_drive     (out_drive),
  .out_zero_step (out_zero_step),
  .out_clamped   (out_clamped)
);

`default_nettype wire

>>> sim/pid_controller_clamped_test.sv
// self-checking testbench of pid_controller_clamped: directed table plus random control steps
// checked against an in-bench fixed-point pid predictor; depends on hdl/pidc_pkg.sv and the rtl
module pid_controller_clamped_test
  import pidc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW           = DATA_WIDTH_DEF;
  localparam int CFG_W        = (DW > GAIN_W) ? DW : GAIN_W;
  localparam int RANDOM_ITEMS = 1428;
  localparam int CHUNK        = 119;   // random steps between register settings
  localparam int SETTLE       = 60;    // idle clocks after the last result, before the verdict

  localparam logic OP_STEP = 1'b0;
  // index with no register behind it, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic                 operation;
    logic signed [DW-1:0] target;
    logic signed [DW-1:0] measured;
    logic [DT_W-1:0]      time_step;
  } pid_item_t;

  typedef struct packed {
    logic signed [DW-1:0] drive;
    logic                 zero_step;
    logic                 clamped;
  } pid_result_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  // one line of the directed table: a register write or an input item,
  // optionally with its result typed in
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_W-1:0]     reg_value;
    pid_item_t            item;
    logic                 pinned;
    pid_result_t          result;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_operation = 1'b0;
  logic signed [DW-1:0] in_target = '0;
  logic signed [DW-1:0] in_measured = '0;
  logic [DT_W-1:0]      in_time_step = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] out_drive;
  logic                 out_zero_step;
  logic                 out_clamped;

  pid_controller_clamped #(.DATA_WIDTH(DW)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_target    (in_target),
    .in_measured  (in_measured),
    .in_time_step (in_time_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_drive    (out_drive),
    .out_zero_step(out_zero_step),
    .out_clamped  (out_clamped)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // percentage of cycles in which each side holds back
  int unsigned send_idle = 37;
  int unsigned recv_idle = 87;
  int unsigned mismatches = 0;

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // predictor copy of the register file, reset values
  logic signed [DW-1:0]     lim_hi = 16'sh7FFF;
  logic signed [DW-1:0]     lim_lo = 16'sh8000;
  logic signed [GAIN_W-1:0] kp = GAIN_P_RST;
  logic signed [GAIN_W-1:0] kd = GAIN_D_RST;
  logic signed [GAIN_W-1:0] ki = GAIN_I_RST;

  // predictor loop state: previous error and q40.8 error integral
  longint prev_error = 0;
  longint integral_acc = 0;

  // results still owed by the block, oldest first
  pid_result_t predicted_out[$];

  // a typed-in result for the item now on the input, overrides the predictor
  logic        pin_hold = 1'b0;
  pid_result_t pin_result = '0;

  plan_row_t plan[$];

  function automatic longint clip48(longint v);
    if (v > longint'(INTEG_MAX)) return longint'(INTEG_MAX);
    if (v < longint'(INTEG_MIN)) return longint'(INTEG_MIN);
    return v;
  endfunction

  function automatic longint add_sat64(longint a, longint b);
    if (b > 0 && a > S64_MAX - b) return S64_MAX;
    if (b < 0 && a < S64_MIN - b) return S64_MIN;
    return a + b;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      REG_OUT_MAX: lim_hi = value[DW-1:0];
      REG_OUT_MIN: lim_lo = value[DW-1:0];
      REG_GAIN_P:  kp = value[GAIN_W-1:0];
      REG_GAIN_D:  kd = value[GAIN_W-1:0];
      REG_GAIN_I:  ki = value[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // one control step of the fixed-point pid, advancing the predictor state
  function automatic pid_result_t pid_update(pid_item_t it);
    pid_result_t r;
    longint      err, dt, p_term, i_term, d_term, rate, sum;
    r = '0;
    if (it.operation == OP_CLEAR) begin
      integral_acc = 0;
      prev_error = 0;
      return r;
    end
    err = longint'($signed(it.target)) - longint'($signed(it.measured));
    dt = longint'(it.time_step);
    integral_acc = clip48(integral_acc + err * dt);
    // p is q.8 times the error, moved up to q.16
    p_term = longint'(kp) * err * 256;
    i_term = longint'(ki) * integral_acc;
    if (dt == 0) begin
      r.zero_step = 1'b1;
      d_term = 0;
    end else begin
      // signed divide truncates toward zero
      rate = clip48(((err - prev_error) * 65536) / dt);
      d_term = longint'(kd) * rate;
    end
    sum = add_sat64(add_sat64(p_term, i_term), d_term);
    // upper limit tested first, which matters when the limits cross
    if (sum > longint'(lim_hi) * 65536) begin
      r.drive = lim_hi;
      r.clamped = 1'b1;
    end else if (sum < longint'(lim_lo) * 65536) begin
      r.drive = lim_lo;
      r.clamped = 1'b1;
    end else begin
      r.drive = DW'(sum >>> FRAC_W);
    end
    prev_error = err;
    return r;
  endfunction

  // sample at the rising edge: register writes, input transfers, result transfers
  always @(posedge clk) begin
    pid_item_t   seen;
    pid_result_t want;
    if (rst_n) begin
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        seen = '{in_operation, in_target, in_measured, in_time_step};
        want = pid_update(seen);
        predicted_out.push_back(pin_hold ? pin_result : want);
      end
      if (out_valid && out_ready) begin
        if (predicted_out.size() == 0) begin
          $error("result transfer with nothing outstanding: drive %0d", out_drive);
          mismatches++;
        end else begin
          want = predicted_out.pop_front();
          if (out_drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive), out_drive);
            mismatches++;
          end
          if (out_zero_step !== want.zero_step) begin
            $error("zero_step: expected %0b, got %0b", want.zero_step, out_zero_step);
            mismatches++;
          end
          if (out_clamped !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, out_clamped);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic plan_row_t item_row(logic op, int t, int m, int dt);
    plan_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = '{op, DW'(t), DW'(m), DT_W'(dt)};
    return r;
  endfunction

  function automatic plan_row_t known_row(logic op, int t, int m, int dt,
                                          int drive, logic zs, logic cl);
    plan_row_t r;
    r = item_row(op, t, m, dt);
    r.pinned = 1'b1;
    r.result = '{DW'(drive), zs, cl};
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int value);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.reg_index = idx;
    r.reg_value = CFG_W'(value);
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return GAIN_W'($urandom_range(128) - 64);
      2:       return GAIN_W'($urandom_range(2048) - 1024);
      3:       return GAIN_W'($urandom);
      default: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic logic [DW-1:0] random_level();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1, 2, 3: return DW'($urandom_range(400) - 200);
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic pid_item_t random_item();
    pid_item_t   it;
    int unsigned pick;
    it.operation = ($urandom_range(99) < 4) ? OP_CLEAR : OP_STEP;
    it.target = random_level();
    // often keep the error small so the output lands inside the limits
    if ($urandom_range(2) == 0) it.measured = DW'(it.target + $urandom_range(64) - 32);
    else it.measured = random_level();
    pick = $urandom_range(99);
    if (pick < 6) it.time_step = '0;
    else if (pick < 20) it.time_step = DT_W'($urandom_range(16, 1));
    else if (pick < 23) it.time_step = 16'hFFFF;
    else if (pick < 30) it.time_step = 16'h0100;
    else it.time_step = DT_W'($urandom);
    return it;
  endfunction

  // hold the input low until every owed result has been taken
  task automatic await_results();
    in_valid <= 1'b0;
    while (predicted_out.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  // new register set for one stretch of random steps; first two are the extremes
  task automatic load_settings(int k);
    logic [CFG_W-1:0] hi, lo;
    if (k == 0) begin
      hi = 16'h7FFF;
      lo = 16'h8000;
    end else if (k == 1) begin
      hi = 16'h8000;
      lo = 16'h7FFF;
    end else begin
      case ($urandom_range(3))
        0: begin
          hi = 16'h7FFF;
          lo = 16'h8000;
        end
        1: begin
          hi = CFG_W'($urandom_range(32767));
          lo = CFG_W'(-$urandom_range(32768));
        end
        2: begin
          // crossed limits
          hi = CFG_W'(-$urandom_range(2000, 1));
          lo = CFG_W'($urandom_range(2000, 1));
        end
        default: begin
          hi = CFG_W'($urandom);
          lo = CFG_W'($urandom);
        end
      endcase
    end
    write_reg(REG_OUT_MAX, hi);
    write_reg(REG_OUT_MIN, lo);
    write_reg(REG_GAIN_P, (k == 0) ? 16'h7FFF : (k == 1) ? 16'h8000 : random_gain());
    write_reg(REG_GAIN_D, (k == 0) ? 16'h7FFF : (k == 1) ? 16'h8000 : random_gain());
    write_reg(REG_GAIN_I, (k == 0) ? 16'h7FFF : (k == 1) ? 16'h8000 : random_gain());
  endtask

  // present one item and return at the falling edge after its transfer;
  // in_valid stays high so the caller either retargets it or lowers it
  task automatic send_item(pid_item_t it);
    cfg_we <= 1'b0;
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= it.operation;
    in_target <= it.target;
    in_measured <= it.measured;
    in_time_step <= it.time_step;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    // reset defaults: gain_p is 1.0 and the other gains 0, so drive is the clamped error
    plan.push_back(known_row(OP_STEP, 100, 40, 256, 60, 1'b0, 1'b0));
    plan.push_back(known_row(OP_STEP, 32767, -32768, 65535, 32767, 1'b0, 1'b1));
    plan.push_back(known_row(OP_STEP, -32768, 32767, 1, -32768, 1'b0, 1'b1));
    // zero time step skips the derivative and raises the flag
    plan.push_back(known_row(OP_STEP, 5, 5, 0, 0, 1'b1, 1'b0));
    plan.push_back(known_row(OP_STEP, -1, 0, 0, -1, 1'b1, 1'b0));
    // clear returns all zero whatever the other fields hold
    plan.push_back(known_row(OP_CLEAR, 32767, -32768, 65535, 0, 1'b0, 1'b0));
    // sums sitting exactly on a limit are not clamped; one just above the limit is
    plan.push_back(known_row(OP_STEP, 32767, 0, 32768, 32767, 1'b0, 1'b0));
    plan.push_back(known_row(OP_STEP, -32768, 0, 128, -32768, 1'b0, 1'b0));
    plan.push_back(known_row(OP_STEP, 0, -32768, 256, 32767, 1'b0, 1'b1));
    // write to an index with no register: gain_p must still be 1.0
    plan.push_back(reg_row(REG_NONE, 0));
    plan.push_back(known_row(OP_STEP, 7, 0, 1, 7, 1'b0, 1'b0));
    // integral and derivative paths
    plan.push_back(reg_row(REG_GAIN_I, 256));
    plan.push_back(reg_row(REG_GAIN_D, 256));
    plan.push_back(item_row(OP_STEP, 1000, 0, 256));
    plan.push_back(item_row(OP_STEP, -1000, 0, 1));
    plan.push_back(item_row(OP_STEP, 0, 0, 0));
    plan.push_back(item_row(OP_STEP, 30, -30, 65535));
    plan.push_back(item_row(OP_CLEAR, 0, 0, 0));
    // narrow window
    plan.push_back(reg_row(REG_OUT_MAX, 100));
    plan.push_back(reg_row(REG_OUT_MIN, -100));
    plan.push_back(item_row(OP_STEP, 50, -60, 2));
    plan.push_back(item_row(OP_STEP, -200, 0, 512));
    // crossed limits
    plan.push_back(reg_row(REG_OUT_MAX, -50));
    plan.push_back(reg_row(REG_OUT_MIN, 50));
    plan.push_back(item_row(OP_STEP, 0, 0, 256));
    plan.push_back(item_row(OP_STEP, 1, 0, 256));
    plan.push_back(item_row(OP_STEP, -1, 0, 256));
    // extreme gains
    plan.push_back(reg_row(REG_GAIN_P, -32768));
    plan.push_back(reg_row(REG_GAIN_D, 32767));
    plan.push_back(reg_row(REG_GAIN_I, -32768));
    plan.push_back(reg_row(REG_OUT_MAX, 32767));
    plan.push_back(reg_row(REG_OUT_MIN, -32768));
    plan.push_back(item_row(OP_STEP, 32767, -32768, 1));
    plan.push_back(item_row(OP_STEP, -32768, 32767, 65535));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, sender idle 37 percent, receiver 87 percent
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        await_results();
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        pin_hold = plan[i].pinned;
        pin_result = plan[i].result;
        send_item(plan[i].item);
      end
    end
    pin_hold = 1'b0;

    // random steps, register set changed between stretches
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle = 87;
        recv_idle = 37;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (n % CHUNK == 0) begin
        await_results();
        load_settings(n / CHUNK);
      end else if ($urandom_range(99) == 0) begin
        // let the pipe run dry now and then
        await_results();
      end
      send_item(random_item());
    end

    await_results();
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("pid_controller_clamped: match");
    end else begin
      $display("pid_controller_clamped: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("pid_controller_clamped: mismatch");
    $finish;
  end

endmodule
